/* rtl/msf_pkg.sv */
// ============================================================================
// msf_pkg: shared types, constants and arithmetic for the shape evaluator
// Holds the item descriptor that travels down the lane pipeline, the
// fixed-point multiply with rounding and the corner-sign table.
// ============================================================================
package msf_pkg;

  localparam int FRAC_BITS = 14;
  localparam int MAX_DIMS  = 3;
  localparam int LANES     = 2 ** MAX_DIMS;
  localparam int LANE_BITS = $clog2(LANES);
  localparam int CNT_W     = LANE_BITS + 1;
  localparam int ETA_W     = 16;
  localparam int VAL_W     = 16;
  localparam int ACC_W     = 18;
  localparam int PROD_W    = 2 * ACC_W;

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [1:0]        GRAD_NONE  = 2'd3;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [ETA_W-1:0] eta_t;
  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [1:0] {
    MODE_ALL_VALUES  = 2'd0,
    MODE_ONE_VALUE   = 2'd1,
    MODE_GRAD_VECTOR = 2'd2,
    MODE_GRAD_COMP   = 2'd3
  } mode_t;

  // One request as it moves through the lane pipeline.
  typedef struct packed {
    mode_t            mode;
    logic [2:0]       node;
    logic [1:0]       comp;
    logic [1:0]       dims;
    logic             bad;
    logic [CNT_W-1:0] count;
    eta_t             eta_x;
    eta_t             eta_y;
    eta_t             eta_z;
  } item_t;

  // Advance strobes of the three multiply steps.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } lane_en_t;

  // Dimension count as used by the arithmetic: zero counts as one.
  function automatic logic [1:0] dims_eff(input logic [1:0] d);
    logic [1:0] r;
    r = d;
    if (d == 2'd0) begin
      r = 2'd1;
    end
    if (d > 2'(MAX_DIMS)) begin
      r = 2'(MAX_DIMS);
    end
    return r;
  endfunction

  // Corner sign of node n along direction i: 1 for plus, 0 for minus.
  function automatic logic corner_plus(input logic [2:0] n, input logic [1:0] i);
    logic p;
    case (i)
      2'd0:    p = n[0] ^ n[1];
      2'd1:    p = n[1];
      2'd2:    p = n[2];
      default: p = 1'b0;
    endcase
    return p;
  endfunction

  // Fixed-point product scaled down by 2^FRAC_BITS, ties away from zero.
  function automatic acc_t mul_round(input acc_t a, input acc_t f);
    logic signed [PROD_W-1:0] p;
    logic [PROD_W-1:0]        mag;
    logic [PROD_W-1:0]        r;
    p   = PROD_W'(a) * PROD_W'(f);
    mag = p[PROD_W-1] ? (PROD_W'(0) - p) : p;
    r   = (mag + ROUND_HALF) >> FRAC_BITS;
    return p[PROD_W-1] ? (ACC_W'(0) - r[ACC_W-1:0]) : r[ACC_W-1:0];
  endfunction

  // One multiply step of a lane: factor of direction dim for this lane's node.
  function automatic acc_t lane_step(input acc_t a, input item_t it,
                                     input logic [LANE_BITS-1:0] lane,
                                     input logic [1:0] dim);
    logic [2:0] n;
    logic [1:0] g;
    logic       plus;
    eta_t       e;
    acc_t       one;
    acc_t       ext;
    acc_t       f;
    one = ACC_W'(1) << FRAC_BITS;
    n   = (it.mode == MODE_ALL_VALUES) ? 3'(lane) : it.node;
    case (it.mode)
      MODE_GRAD_VECTOR: g = 2'(lane);
      MODE_GRAD_COMP:   g = it.comp;
      default:          g = GRAD_NONE;
    endcase
    case (dim)
      2'd0:    e = it.eta_x;
      2'd1:    e = it.eta_y;
      default: e = it.eta_z;
    endcase
    ext  = ACC_W'(e);
    plus = corner_plus(n, dim);
    if (dim == g) begin
      f = plus ? one : (ACC_W'(0) - one);
    end else begin
      f = plus ? (one + ext) : (one - ext);
    end
    if (dim >= it.dims) begin
      return a;
    end
    return mul_round(a, f);
  endfunction

  // Clamp to the 16-bit result range.
  function automatic val_t sat_val(input acc_t a);
    val_t r;
    if (a > ACC_W'(32767)) begin
      r = 16'sh7FFF;
    end else if (a < -ACC_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = a[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/msf_lane.sv */
// ============================================================================
// msf_lane: one evaluation lane
// Three pipelined multiply-and-round steps, one per spatial direction,
// building the product for the node and direction assigned to this lane.
// ============================================================================
module msf_lane (
  input  logic                           clk,
  input  logic [msf_pkg::LANE_BITS-1:0]  lane_id,
  input  msf_pkg::lane_en_t              en,
  input  msf_pkg::item_t                 item0,
  input  msf_pkg::item_t                 item1,
  input  msf_pkg::item_t                 item2,
  output msf_pkg::acc_t                  acc_out
);
  import msf_pkg::*;

  acc_t acc1_r;
  acc_t acc2_r;
  acc_t acc3_r;
  acc_t start;

  // The running product starts at 2^-d, which is exact.
  assign start = acc_t'(ACC_W'(1) << (FRAC_BITS - int'(item0.dims)));

  // One direction per stage; directions beyond d pass the product through.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      acc1_r <= lane_step(start, item0, lane_id, 2'd0);
    end
    if (en.s2) begin
      acc2_r <= lane_step(acc1_r, item1, lane_id, 2'd1);
    end
    if (en.s3) begin
      acc3_r <= lane_step(acc2_r, item2, lane_id, 2'd2);
    end
  end

  assign acc_out = acc3_r;

endmodule

/* rtl/msf_merge.sv */
// ============================================================================
// msf_merge: result merging and output stage
// Takes the finished lane products of one request, saturates them, and
// sends the request's results with their indexes, one word per cycle while out_ready is high.
// ============================================================================
module msf_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_valid,
  input  msf_pkg::item_t      load_item,
  input  msf_pkg::acc_t       lane_acc [msf_pkg::LANES],
  output logic                load_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output msf_pkg::val_t       out_result_value,
  output logic [2:0]          out_node_index,
  output logic [1:0]          out_component_index,
  output logic                out_is_gradient,
  output logic                out_bad_request,
  output logic                out_last
);
  import msf_pkg::*;

  logic                 busy_r;
  logic [LANE_BITS-1:0] idx_r;
  item_t                item_r;
  val_t                 val_r [LANES];
  logic                 is_last;
  logic                 load;

  assign is_last = (CNT_W'(idx_r) + CNT_W'(1)) == item_r.count;
  assign load_ok = !busy_r || (out_ready && is_last);
  assign load    = load_valid && load_ok;

  // Control: a batch is held until its last word is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (busy_r && out_ready) begin
      if (is_last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + LANE_BITS'(1);
      end
    end
  end

  // Batch storage: saturated lane results and the request descriptor.
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
      for (int k = 0; k < LANES; k++) begin
        val_r[k] <= sat_val(lane_acc[k]);
      end
    end
  end

  // Output word for the current position in the batch.
  always_comb begin
    out_valid           = busy_r;
    out_last            = is_last;
    out_bad_request     = item_r.bad;
    out_result_value    = item_r.bad ? '0 : val_r[idx_r];
    out_is_gradient     = (item_r.mode == MODE_GRAD_VECTOR) ||
                          (item_r.mode == MODE_GRAD_COMP);
    out_node_index      = (item_r.mode == MODE_ALL_VALUES) ? 3'(idx_r) : item_r.node;
    case (item_r.mode)
      MODE_GRAD_VECTOR: out_component_index = 2'(idx_r);
      MODE_GRAD_COMP:   out_component_index = item_r.comp;
      default:          out_component_index = 2'd0;
    endcase
  end

endmodule

/* rtl/multilinear_shape_function_eval.sv */
// ============================================================================
// multilinear_shape_function_eval: linear/bilinear/trilinear shape functions
// Evaluates the shape function values or gradients of a hypercube element
// at a natural coordinate, with eight node lanes working side by side.
// ============================================================================
// Usage:
//   The input channel (in_valid/in_ready) takes one request word: mode, node,
//   component and the Q2.14 coordinates. The result channel
//   (out_valid/out_ready) returns one word per result; out_last marks the
//   final word of a request. A request gives 2^d words for all node values,
//   d words for a gradient vector, and one word otherwise; a flagged request
//   always gives a single word.
//   The request passes the three multiply stages, the first loaded at the
//   edge that accepts it, and then the merge register before its first
//   result word is valid.
//   Throughput: the output stage sends one word per cycle while out_ready
//   is high, so a request occupies it until all its results are sent, up to
//   eight for all node values in three dimensions. The lane pipeline keeps
//   taking new requests while a batch is being sent.
//   When the receiver stalls, the current word holds and the pipeline fills
//   up to three requests before in_ready drops.
//   The space_dims register sits at byte address 0 of the APB port and must
//   be written only while the block is idle; the block does not enforce
//   this. Reset empties the pipeline and sets space_dims to 2.
// ============================================================================
module multilinear_shape_function_eval (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_mode,
  input  logic [2:0]           in_node,
  input  logic [1:0]           in_component,
  input  msf_pkg::eta_t        in_eta_x,
  input  msf_pkg::eta_t        in_eta_y,
  input  msf_pkg::eta_t        in_eta_z,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output msf_pkg::val_t        out_result_value,
  output logic [2:0]           out_node_index,
  output logic [1:0]           out_component_index,
  output logic                 out_is_gradient,
  output logic                 out_bad_request,
  output logic                 out_last
);
  import msf_pkg::*;

  logic [1:0] space_dims_r;
  logic       cfg_sel;
  logic       v1_r, v2_r, v3_r;
  item_t      it1_r, it2_r, it3_r;
  item_t      item0;
  lane_en_t   en;
  logic       load_ok;
  acc_t       lane_acc [LANES];
  logic [1:0] dims;
  logic [CNT_W-1:0] nodes;

  // Register file: space_dims at word 0.
  assign cfg_sel = !paddr[2];
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? {30'd0, space_dims_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_dims_r <= 2'd2;
    end else if (psel && penable && pwrite && cfg_sel) begin
      space_dims_r <= pwdata[1:0];
    end
  end

  // Request decode: result count and range check.
  always_comb begin
    dims        = dims_eff(space_dims_r);
    nodes       = CNT_W'(1) << dims;
    item0.mode  = mode_t'(in_mode);
    item0.node  = in_node;
    item0.comp  = in_component;
    item0.dims  = dims;
    item0.eta_x = in_eta_x;
    item0.eta_y = in_eta_y;
    item0.eta_z = in_eta_z;
    item0.bad   = (item0.mode != MODE_ALL_VALUES) &&
                  ((CNT_W'(in_node) >= nodes) ||
                   ((item0.mode == MODE_GRAD_COMP) && (in_component >= dims)));
    if (item0.mode == MODE_ALL_VALUES) begin
      item0.count = nodes;
    end else if (!item0.bad && (item0.mode == MODE_GRAD_VECTOR)) begin
      item0.count = CNT_W'(dims);
    end else begin
      item0.count = CNT_W'(1);
    end
  end

  // Stage advance: each stage moves when it is empty or the next one moves.
  assign en.s3    = !v3_r || load_ok;
  assign en.s2    = !v2_r || en.s3;
  assign en.s1    = !v1_r || en.s2;
  assign in_ready = en.s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en.s1) begin
        v1_r <= in_valid;
      end
      if (en.s2) begin
        v2_r <= v1_r;
      end
      if (en.s3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      it1_r <= item0;
    end
    if (en.s2) begin
      it2_r <= it1_r;
    end
    if (en.s3) begin
      it3_r <= it2_r;
    end
  end

  // One lane per node position.
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    msf_lane u_lane (
      .clk     (clk),
      .lane_id (LANE_BITS'(k)),
      .en      (en),
      .item0   (item0),
      .item1   (it1_r),
      .item2   (it2_r),
      .acc_out (lane_acc[k])
    );
  end

  // Merge the lane results into the output word stream.
  msf_merge u_merge (
    .clk                 (clk),
    .rst_n               (rst_n),
    .load_valid          (v3_r),
    .load_item           (it3_r),
    .lane_acc            (lane_acc),
    .load_ok             (load_ok),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_value    (out_result_value),
    .out_node_index      (out_node_index),
    .out_component_index (out_component_index),
    .out_is_gradient     (out_is_gradient),
    .out_bad_request     (out_bad_request),
    .out_last            (out_last)
  );

endmodule

/* rtl/msf_checker.sv */
// ============================================================================
// msf_checker: port-level checks for the shape function evaluator
// Watches the result channel over time and is bound to the top level.
// ============================================================================
module msf_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input msf_pkg::val_t        out_result_value,
  input logic [2:0]           out_node_index,
  input logic [1:0]           out_component_index,
  input logic                 out_is_gradient,
  input logic                 out_bad_request,
  input logic                 out_last
);
  import msf_pkg::*;

  // A stalled result word holds its value, node index and last flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value) &&
    $stable(out_node_index) && $stable(out_last))
    else $error("result word changed while stalled");

  // A rejected request gives one word with a zero value.
  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_request |-> out_last && (out_result_value == '0))
    else $error("flagged result is not a single zero word");

  // Value results carry direction zero.
  a_value_comp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_gradient |-> out_component_index == 2'd0)
    else $error("value result with nonzero direction");

  // The words of one request follow without gaps.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a result batch");

  // Reset empties the output stage.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind multilinear_shape_function_eval msf_checker u_msf_checker (.*);
